// File: hdl/dpc_pkg.sv
// Shared types and constants for the dispenser payment controller.
// Depends on nothing; used by dpc_step and dispenser_payment_controller.
`default_nettype none

package dpc_pkg;

    // Fixed timing constant of the dispense timer
    localparam int TICKS_PER_SECOND = 1000;

    localparam logic [9:0] CREDIT_MAX = 10'd1023;

    // Commands carried by an input word
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_COIN   = 2'd1;
    localparam logic [1:0] CMD_MENU   = 2'd2;
    localparam logic [1:0] CMD_NOZZLE = 2'd3;

    // Menu states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_PRICES   = 4'd1;
    localparam logic [3:0] ST_QR_WAIT  = 4'd2;
    localparam logic [3:0] ST_PAID     = 4'd3;
    localparam logic [3:0] ST_COIN     = 4'd4;
    localparam logic [3:0] ST_PRODUCT  = 4'd5;
    localparam logic [3:0] ST_VOLUME   = 4'd6;
    localparam logic [3:0] ST_CONFIRM  = 4'd7;
    localparam logic [3:0] ST_DISPENSE = 4'd8;

    // Coin window outcome codes
    localparam logic [1:0] COIN_NONE     = 2'd0;
    localparam logic [1:0] COIN_ACCEPTED = 2'd1;
    localparam logic [1:0] COIN_UNKNOWN  = 2'd2;
    localparam logic [1:0] COIN_IGNORED  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_PRICE_ONE     = 3'd0;
    localparam logic [2:0] REG_PRICE_TWO     = 3'd1;
    localparam logic [2:0] REG_PRICE_THREE   = 3'd2;
    localparam logic [2:0] REG_DISPENSE_SECS = 3'd3;
    localparam logic [2:0] REG_COIN_WINDOW   = 3'd4;
    localparam logic [2:0] REG_KEY_LOCKOUT   = 3'd5;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] key_number;
    } in_word_t;

    typedef struct packed {
        logic [3:0] mode;
        logic [9:0] balance;
        logic [1:0] chosen_product;
        logic [1:0] chosen_volume;
        logic [8:0] purchase_cost;
        logic [1:0] pump_active;
        logic       coin_enable;
        logic [5:0] seconds_left;
        logic       short_of_funds;
        logic [1:0] coin_outcome;
    } out_word_t;

    typedef struct packed {
        logic [7:0]  price_product_one;
        logic [7:0]  price_product_two;
        logic [7:0]  price_product_three;
        logic [5:0]  dispense_seconds;
        logic [15:0] coin_window_ticks;
        logic [15:0] key_lockout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  menu_state;
        logic [9:0]  credit;
        logic [1:0]  product_choice;
        logic [1:0]  volume_choice;
        logic [8:0]  cost_held;
        logic        coin_counting;
        logic [3:0]  coin_pulse_count;
        logic [15:0] coin_window_elapsed;
        logic [15:0] lockout_elapsed;
        logic [9:0]  subsecond_count;
        logic [5:0]  seconds_remaining;
        logic [1:0]  running_pump;
    } state_t;

endpackage

`default_nettype wire

// File: hdl/dpc_step.sv
// Next-state and result logic for one input word of the payment controller.
// Purely combinational; depends on dpc_pkg.
`default_nettype none

module dpc_step (
    input  wire dpc_pkg::state_t    cur,
    input  wire dpc_pkg::cfg_t      cfg,
    input  wire dpc_pkg::in_word_t  word,
    output dpc_pkg::state_t         nxt,
    output dpc_pkg::out_word_t      res
);

    logic        in_coin_state;
    logic        nxt_coin_state;
    logic [2:0]  coin_val;
    logic [10:0] credit_add;
    logic [10:0] sub_inc;
    logic        done;
    logic        lockout_ok;
    logic        menu_key_ok;
    logic        nozzle_key_ok;
    logic [7:0]  base_price;
    logic [8:0]  new_cost;
    logic        short_flag;
    logic [1:0]  outcome;

    assign in_coin_state = (cur.menu_state == dpc_pkg::ST_COIN) ||
                           (cur.menu_state == dpc_pkg::ST_PRODUCT) ||
                           (cur.menu_state == dpc_pkg::ST_VOLUME);

    // 2, 4 and 7 pulses are the only recognized coins
    always_comb begin
        case (cur.coin_pulse_count)
            4'd2:    coin_val = 3'd1;
            4'd4:    coin_val = 3'd2;
            4'd7:    coin_val = 3'd5;
            default: coin_val = 3'd0;
        endcase
    end

    assign credit_add = {1'b0, cur.credit} + {8'd0, coin_val};
    assign sub_inc    = {1'b0, cur.subsecond_count} + 11'd1;

    assign lockout_ok    = cur.lockout_elapsed > cfg.key_lockout_ticks;
    assign menu_key_ok   = (word.key_number != 3'd0) && (word.key_number <= 3'd4);
    assign nozzle_key_ok = (word.key_number != 3'd0) && (word.key_number <= 3'd3);

    always_comb begin
        case (cur.product_choice)
            2'd1:    base_price = cfg.price_product_one;
            2'd2:    base_price = cfg.price_product_two;
            2'd3:    base_price = cfg.price_product_three;
            default: base_price = 8'd0;
        endcase
    end

    always_comb begin
        case (word.key_number)
            3'd1:    new_cost = {2'b00, base_price[7:1]};
            3'd2:    new_cost = {1'b0, base_price};
            default: new_cost = {base_price, 1'b0};
        endcase
    end

    always_comb begin
        nxt        = cur;
        short_flag = 1'b0;
        outcome    = dpc_pkg::COIN_NONE;
        done       = 1'b0;
        case (word.cmd)
            dpc_pkg::CMD_TICK: begin
                if (cur.lockout_elapsed != 16'hFFFF) begin
                    nxt.lockout_elapsed = cur.lockout_elapsed + 16'd1;
                end
                // coin window first, then the dispense timer
                if (cur.coin_counting) begin
                    if (cur.coin_window_elapsed != 16'hFFFF) begin
                        nxt.coin_window_elapsed = cur.coin_window_elapsed + 16'd1;
                    end
                    if (nxt.coin_window_elapsed >= cfg.coin_window_ticks) begin
                        nxt.coin_counting       = 1'b0;
                        nxt.coin_pulse_count    = 4'd0;
                        nxt.coin_window_elapsed = 16'd0;
                        if (!in_coin_state) begin
                            outcome = dpc_pkg::COIN_IGNORED;
                        end else if (coin_val == 3'd0) begin
                            outcome = dpc_pkg::COIN_UNKNOWN;
                        end else begin
                            outcome    = dpc_pkg::COIN_ACCEPTED;
                            nxt.credit = credit_add[10] ? dpc_pkg::CREDIT_MAX
                                                        : credit_add[9:0];
                        end
                    end
                end
                if (cur.menu_state == dpc_pkg::ST_DISPENSE) begin
                    done = (cur.seconds_remaining == 6'd0);
                    if (!done) begin
                        if (sub_inc >= 11'(dpc_pkg::TICKS_PER_SECOND)) begin
                            nxt.subsecond_count   = 10'd0;
                            nxt.seconds_remaining = cur.seconds_remaining - 6'd1;
                            done = (nxt.seconds_remaining == 6'd0);
                        end else begin
                            nxt.subsecond_count = sub_inc[9:0];
                        end
                    end
                    if (done) begin
                        nxt.running_pump      = 2'd0;
                        nxt.subsecond_count   = 10'd0;
                        nxt.seconds_remaining = 6'd0;
                        nxt.menu_state = (nxt.credit != 10'd0) ? dpc_pkg::ST_COIN
                                                               : dpc_pkg::ST_IDLE;
                    end
                end
            end
            dpc_pkg::CMD_COIN: begin
                if (!cur.coin_counting) begin
                    nxt.coin_counting       = 1'b1;
                    nxt.coin_window_elapsed = 16'd0;
                end
                if (cur.coin_pulse_count != 4'd15) begin
                    nxt.coin_pulse_count = cur.coin_pulse_count + 4'd1;
                end
            end
            dpc_pkg::CMD_MENU: begin
                if (menu_key_ok && lockout_ok) begin
                    nxt.lockout_elapsed = 16'd0;
                    unique case (cur.menu_state)
                        dpc_pkg::ST_IDLE: begin
                            if (word.key_number == 3'd1) begin
                                nxt.menu_state = dpc_pkg::ST_QR_WAIT;
                            end else if (word.key_number == 3'd2) begin
                                nxt.menu_state = dpc_pkg::ST_COIN;
                            end else if (word.key_number == 3'd3) begin
                                nxt.menu_state = dpc_pkg::ST_PRICES;
                            end
                        end
                        dpc_pkg::ST_PRICES: begin
                            if (word.key_number == 3'd4) begin
                                nxt.menu_state = dpc_pkg::ST_IDLE;
                            end
                        end
                        dpc_pkg::ST_QR_WAIT: begin
                            if (word.key_number == 3'd1) begin
                                nxt.product_choice = 2'd1;
                                nxt.menu_state     = dpc_pkg::ST_PAID;
                            end else if (word.key_number == 3'd4) begin
                                nxt.menu_state = dpc_pkg::ST_IDLE;
                            end
                        end
                        dpc_pkg::ST_COIN: begin
                            if (word.key_number == 3'd4) begin
                                nxt.menu_state = (cur.credit == 10'd0) ? dpc_pkg::ST_IDLE
                                                                       : dpc_pkg::ST_PRODUCT;
                            end
                        end
                        dpc_pkg::ST_PRODUCT: begin
                            if (word.key_number <= 3'd3) begin
                                nxt.product_choice = word.key_number[1:0];
                                nxt.menu_state     = dpc_pkg::ST_VOLUME;
                            end else begin
                                nxt.menu_state = dpc_pkg::ST_COIN;
                            end
                        end
                        dpc_pkg::ST_VOLUME: begin
                            if (word.key_number <= 3'd3) begin
                                nxt.volume_choice = word.key_number[1:0];
                                nxt.cost_held     = new_cost;
                                // cost is recorded even when funds fall short
                                if (cur.credit >= {1'b0, new_cost}) begin
                                    nxt.menu_state = dpc_pkg::ST_CONFIRM;
                                end else begin
                                    short_flag = 1'b1;
                                end
                            end else begin
                                nxt.menu_state = dpc_pkg::ST_PRODUCT;
                            end
                        end
                        dpc_pkg::ST_CONFIRM: begin
                            if (word.key_number == 3'd1) begin
                                nxt.credit = (cur.credit >= {1'b0, cur.cost_held})
                                           ? cur.credit - {1'b0, cur.cost_held}
                                           : 10'd0;
                                nxt.menu_state = dpc_pkg::ST_PAID;
                            end else if (word.key_number == 3'd4) begin
                                nxt.menu_state = dpc_pkg::ST_VOLUME;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                // nozzle key
                if (nozzle_key_ok && lockout_ok) begin
                    nxt.lockout_elapsed = 16'd0;
                    if ((cur.menu_state == dpc_pkg::ST_PAID) &&
                        (word.key_number[1:0] == cur.product_choice)) begin
                        nxt.running_pump      = word.key_number[1:0];
                        nxt.seconds_remaining = cfg.dispense_seconds;
                        nxt.subsecond_count   = 10'd0;
                        nxt.menu_state        = dpc_pkg::ST_DISPENSE;
                    end
                end
            end
        endcase
    end

    assign nxt_coin_state = (nxt.menu_state == dpc_pkg::ST_COIN) ||
                            (nxt.menu_state == dpc_pkg::ST_PRODUCT) ||
                            (nxt.menu_state == dpc_pkg::ST_VOLUME);

    always_comb begin
        res.mode           = nxt.menu_state;
        res.balance        = nxt.credit;
        res.chosen_product = nxt.product_choice;
        res.chosen_volume  = nxt.volume_choice;
        res.purchase_cost  = nxt.cost_held;
        res.pump_active    = nxt.running_pump;
        res.coin_enable    = nxt_coin_state && !nxt.coin_counting;
        res.seconds_left   = (nxt.menu_state == dpc_pkg::ST_DISPENSE)
                           ? nxt.seconds_remaining : 6'd0;
        res.short_of_funds = short_flag;
        res.coin_outcome   = outcome;
    end

endmodule

`default_nettype wire

// File: hdl/dispenser_payment_controller.sv
// Top level of the dispenser payment controller: handshake, config registers, state.
// Depends on dpc_pkg and dpc_step.
`default_nettype none

// Dispenser payment controller. Every input word (millisecond tick, coin
// pulse, menu key or nozzle key) yields exactly one result word carrying the
// menu mode, balance, selection, cost, pump and coin status. The block takes
// one word per clock cycle when the result side keeps up; a word passes the
// input register, then the result register, and the state update for one
// word is done as it moves from the input register to the result register.
// The input register refills while a result waits, so a stalled output blocks
// input only once both registers are full. Configuration (prices, dispense
// time, coin window, key lockout) is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while no word is in flight (the block does not
// enforce this); writes to indexes beyond the register list are dropped.

module dispenser_payment_controller (
    input  wire                     aclk,
    input  wire                     aresetn,
    // config write port
    input  wire                     cfg_we,
    input  wire [2:0]               cfg_index,
    input  wire [15:0]              cfg_data,
    // input words
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire dpc_pkg::in_word_t  s_data,
    // result words
    output logic                    m_valid,
    input  wire                     m_ready,
    output dpc_pkg::out_word_t      m_data
);

    dpc_pkg::cfg_t      cfg_reg;
    dpc_pkg::state_t    state_reg;
    dpc_pkg::state_t    state_next;
    dpc_pkg::in_word_t  in_word_reg;
    logic               in_valid_reg;
    dpc_pkg::out_word_t out_word_reg;
    dpc_pkg::out_word_t out_word_next;
    logic               out_valid_reg;
    logic               advance;

    // move a word from the input register to the result register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.price_product_one   <= 8'd4;
            cfg_reg.price_product_two   <= 8'd6;
            cfg_reg.price_product_three <= 8'd8;
            cfg_reg.dispense_seconds    <= 6'd10;
            cfg_reg.coin_window_ticks   <= 16'd1000;
            cfg_reg.key_lockout_ticks   <= 16'd250;
        end else if (cfg_we) begin
            unique case (cfg_index)
                dpc_pkg::REG_PRICE_ONE:     cfg_reg.price_product_one   <= cfg_data[7:0];
                dpc_pkg::REG_PRICE_TWO:     cfg_reg.price_product_two   <= cfg_data[7:0];
                dpc_pkg::REG_PRICE_THREE:   cfg_reg.price_product_three <= cfg_data[7:0];
                dpc_pkg::REG_DISPENSE_SECS: cfg_reg.dispense_seconds    <= cfg_data[5:0];
                dpc_pkg::REG_COIN_WINDOW:   cfg_reg.coin_window_ticks   <= cfg_data;
                dpc_pkg::REG_KEY_LOCKOUT:   cfg_reg.key_lockout_ticks   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    dpc_step u_step (
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .word (in_word_reg),
        .nxt  (state_next),
        .res  (out_word_next)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    // controller state, all cleared at reset (menu idle, zero credit)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

`default_nettype wire

// File: test/tb_dispenser_payment_controller.sv
// Self-checking testbench for dispenser_payment_controller: directed and adaptive random words.
// Results are checked against an in-bench model of the menu, coin window and pump timer.
// Depends on dpc_pkg (types, codes, register indexes) and the RTL under hdl/.

module tb_dispenser_payment_controller;

    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [2:0]          cfg_index = '0;
    logic [15:0]         cfg_data  = '0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    dpc_pkg::in_word_t   s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    dpc_pkg::out_word_t  m_data;

    dispenser_payment_controller u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Register values as last written; only changed while nothing is in flight,
    // so the generator and the checking side can share one copy.
    dpc_pkg::cfg_t      settings;
    // Machine state as seen by accepted words, and the generator's look-ahead copy.
    dpc_pkg::state_t    live_state;
    dpc_pkg::state_t    plan_state;

    dpc_pkg::in_word_t  pending_words[$];
    dpc_pkg::out_word_t predicted_words[$];

    int words_in_flight = 0;
    int send_gap        = 0;
    int recv_gap        = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int pulse_target    = 2;
    int results_seen    = 0;
    int error_count     = 0;
    int cycle_count     = 0;
    bit long_hold_done  = 1'b0;

    function automatic bit is_coin_state(input logic [3:0] m);
        return m == dpc_pkg::ST_COIN || m == dpc_pkg::ST_PRODUCT || m == dpc_pkg::ST_VOLUME;
    endfunction

    // One event through the machine: updates st and gives the result word.
    task automatic advance_dispenser(inout dpc_pkg::state_t st, input dpc_pkg::cfg_t cf,
                                     input dpc_pkg::in_word_t w,
                                     output dpc_pkg::out_word_t r);
        logic        short_flag;
        logic [1:0]  outcome;
        logic        done;
        logic [2:0]  coin_units;
        logic [10:0] sum;
        logic [7:0]  base;
        logic [2:0]  k;
        k          = w.key_number;
        short_flag = 1'b0;
        outcome    = dpc_pkg::COIN_NONE;
        case (w.cmd)
            dpc_pkg::CMD_TICK: begin
                if (st.lockout_elapsed != 16'hFFFF)
                    st.lockout_elapsed = st.lockout_elapsed + 16'd1;
                // coin window first, then the pump timer
                if (st.coin_counting) begin
                    if (st.coin_window_elapsed != 16'hFFFF)
                        st.coin_window_elapsed = st.coin_window_elapsed + 16'd1;
                    if (st.coin_window_elapsed >= cf.coin_window_ticks) begin
                        case (st.coin_pulse_count)
                            4'd2:    coin_units = 3'd1;
                            4'd4:    coin_units = 3'd2;
                            4'd7:    coin_units = 3'd5;
                            default: coin_units = 3'd0;
                        endcase
                        st.coin_counting       = 1'b0;
                        st.coin_pulse_count    = '0;
                        st.coin_window_elapsed = '0;
                        if (!is_coin_state(st.menu_state)) begin
                            outcome = dpc_pkg::COIN_IGNORED;
                        end else if (coin_units == 3'd0) begin
                            outcome = dpc_pkg::COIN_UNKNOWN;
                        end else begin
                            outcome   = dpc_pkg::COIN_ACCEPTED;
                            sum       = {1'b0, st.credit} + {8'd0, coin_units};
                            st.credit = (sum > {1'b0, dpc_pkg::CREDIT_MAX})
                                      ? dpc_pkg::CREDIT_MAX : sum[9:0];
                        end
                    end
                end
                if (st.menu_state == dpc_pkg::ST_DISPENSE) begin
                    done = (st.seconds_remaining == 6'd0);
                    if (!done) begin
                        st.subsecond_count = st.subsecond_count + 10'd1;
                        if (st.subsecond_count >= dpc_pkg::TICKS_PER_SECOND) begin
                            st.subsecond_count   = '0;
                            st.seconds_remaining = st.seconds_remaining - 6'd1;
                            done = (st.seconds_remaining == 6'd0);
                        end
                    end
                    if (done) begin
                        st.running_pump      = '0;
                        st.subsecond_count   = '0;
                        st.seconds_remaining = '0;
                        st.menu_state = (st.credit != 10'd0) ? dpc_pkg::ST_COIN
                                                             : dpc_pkg::ST_IDLE;
                    end
                end
            end
            dpc_pkg::CMD_COIN: begin
                if (!st.coin_counting) begin
                    st.coin_counting       = 1'b1;
                    st.coin_window_elapsed = '0;
                end
                if (st.coin_pulse_count != 4'd15)
                    st.coin_pulse_count = st.coin_pulse_count + 4'd1;
            end
            dpc_pkg::CMD_MENU: begin
                if (k >= 3'd1 && k <= 3'd4 && st.lockout_elapsed > cf.key_lockout_ticks) begin
                    st.lockout_elapsed = '0;
                    case (st.menu_state)
                        dpc_pkg::ST_IDLE: begin
                            if (k == 3'd1)      st.menu_state = dpc_pkg::ST_QR_WAIT;
                            else if (k == 3'd2) st.menu_state = dpc_pkg::ST_COIN;
                            else if (k == 3'd3) st.menu_state = dpc_pkg::ST_PRICES;
                        end
                        dpc_pkg::ST_PRICES: begin
                            if (k == 3'd4) st.menu_state = dpc_pkg::ST_IDLE;
                        end
                        dpc_pkg::ST_QR_WAIT: begin
                            if (k == 3'd1) begin
                                st.product_choice = 2'd1;
                                st.menu_state     = dpc_pkg::ST_PAID;
                            end else if (k == 3'd4) begin
                                st.menu_state = dpc_pkg::ST_IDLE;
                            end
                        end
                        dpc_pkg::ST_COIN: begin
                            if (k == 3'd4)
                                st.menu_state = (st.credit == 10'd0) ? dpc_pkg::ST_IDLE
                                                                     : dpc_pkg::ST_PRODUCT;
                        end
                        dpc_pkg::ST_PRODUCT: begin
                            if (k <= 3'd3) begin
                                st.product_choice = k[1:0];
                                st.menu_state     = dpc_pkg::ST_VOLUME;
                            end else begin
                                st.menu_state = dpc_pkg::ST_COIN;
                            end
                        end
                        dpc_pkg::ST_VOLUME: begin
                            if (k <= 3'd3) begin
                                case (st.product_choice)
                                    2'd1:    base = cf.price_product_one;
                                    2'd2:    base = cf.price_product_two;
                                    2'd3:    base = cf.price_product_three;
                                    default: base = 8'd0;
                                endcase
                                st.volume_choice = k[1:0];
                                if (k == 3'd1)      st.cost_held = {2'b00, base[7:1]};
                                else if (k == 3'd2) st.cost_held = {1'b0, base};
                                else                st.cost_held = {base, 1'b0};
                                // too little credit: choice is kept, state stays
                                if (st.credit >= {1'b0, st.cost_held})
                                    st.menu_state = dpc_pkg::ST_CONFIRM;
                                else
                                    short_flag = 1'b1;
                            end else begin
                                st.menu_state = dpc_pkg::ST_PRODUCT;
                            end
                        end
                        dpc_pkg::ST_CONFIRM: begin
                            if (k == 3'd1) begin
                                st.credit = (st.credit >= {1'b0, st.cost_held})
                                          ? st.credit - {1'b0, st.cost_held} : 10'd0;
                                st.menu_state = dpc_pkg::ST_PAID;
                            end else if (k == 3'd4) begin
                                st.menu_state = dpc_pkg::ST_VOLUME;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                // nozzle key
                if (k >= 3'd1 && k <= 3'd3 && st.lockout_elapsed > cf.key_lockout_ticks) begin
                    st.lockout_elapsed = '0;
                    if (st.menu_state == dpc_pkg::ST_PAID && k[1:0] == st.product_choice) begin
                        st.running_pump      = k[1:0];
                        st.seconds_remaining = cf.dispense_seconds;
                        st.subsecond_count   = '0;
                        st.menu_state        = dpc_pkg::ST_DISPENSE;
                    end
                end
            end
        endcase
        r.mode           = st.menu_state;
        r.balance        = st.credit;
        r.chosen_product = st.product_choice;
        r.chosen_volume  = st.volume_choice;
        r.purchase_cost  = st.cost_held;
        r.pump_active    = st.running_pump;
        r.coin_enable    = is_coin_state(st.menu_state) && !st.coin_counting;
        r.seconds_left   = (st.menu_state == dpc_pkg::ST_DISPENSE) ? st.seconds_remaining
                                                                   : 6'd0;
        r.short_of_funds = short_flag;
        r.coin_outcome   = outcome;
    endtask

    // Queue one word and run it through the look-ahead copy of the machine.
    task automatic push_word(input logic [1:0] cmd, input logic [2:0] key);
        dpc_pkg::in_word_t  w;
        dpc_pkg::out_word_t unused;
        w.cmd        = cmd;
        w.key_number = key;
        advance_dispenser(plan_state, settings, w, unused);
        pending_words.push_back(w);
    endtask

    task automatic push_tick();
        push_word(dpc_pkg::CMD_TICK, 3'($urandom_range(0, 7)));
    endtask

    // First pulse of a coin; the generator keeps pulsing until the target count.
    task automatic start_coin(input bit coin_bias);
        int pick;
        pick = $urandom_range(0, 9);
        if (coin_bias)      pulse_target = 7;
        else if (pick < 3)  pulse_target = 2;
        else if (pick < 6)  pulse_target = 4;
        else if (pick < 9)  pulse_target = 7;
        else                pulse_target = $urandom_range(1, 15);
        push_word(dpc_pkg::CMD_COIN, 3'($urandom_range(0, 7)));
    endtask

    // Picks the next word from the look-ahead state: mostly the move that takes
    // the menu forward, with some noise and some keys pressed too early.
    task automatic plan_next(input bit coin_bias);
        int         r;
        int         r2;
        logic [2:0] k;
        logic       want_coin;
        r         = $urandom_range(0, 99);
        r2        = $urandom_range(0, 99);
        k         = 3'($urandom_range(1, 3));
        want_coin = coin_bias && plan_state.credit != dpc_pkg::CREDIT_MAX;
        if (r < 10) begin
            push_word(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
        end else if (plan_state.menu_state == dpc_pkg::ST_DISPENSE) begin
            push_tick();
        end else if (plan_state.coin_counting) begin
            if (plan_state.coin_pulse_count < pulse_target && r < 90)
                push_word(dpc_pkg::CMD_COIN, 3'($urandom_range(0, 7)));
            else
                push_tick();
        end else if (plan_state.lockout_elapsed <= settings.key_lockout_ticks && r < 95) begin
            push_tick();
        end else begin
            case (plan_state.menu_state) inside
                dpc_pkg::ST_IDLE: begin
                    if (coin_bias || r2 < 60) push_word(dpc_pkg::CMD_MENU, 3'd2);
                    else if (r2 < 80)         push_word(dpc_pkg::CMD_MENU, 3'd1);
                    else                      push_word(dpc_pkg::CMD_MENU, 3'd3);
                end
                dpc_pkg::ST_PRICES: begin
                    if (r2 < 80) push_word(dpc_pkg::CMD_MENU, 3'd4);
                    else         push_word(dpc_pkg::CMD_MENU, k);
                end
                dpc_pkg::ST_QR_WAIT: begin
                    if (r2 < 60)      push_word(dpc_pkg::CMD_MENU, 3'd1);
                    else if (r2 < 90) push_word(dpc_pkg::CMD_MENU, 3'd4);
                    else              push_word(dpc_pkg::CMD_MENU, k);
                end
                dpc_pkg::ST_PAID: begin
                    if (r2 < 75)
                        push_word(dpc_pkg::CMD_NOZZLE, {1'b0, plan_state.product_choice});
                    else if (r2 < 90)
                        push_word(dpc_pkg::CMD_NOZZLE, k);
                    else
                        push_word(dpc_pkg::CMD_MENU, 3'($urandom_range(1, 4)));
                end
                dpc_pkg::ST_COIN: begin
                    if (want_coin || (plan_state.credit < 10'd20 && r2 < 50))
                        start_coin(coin_bias);
                    else if (r2 < 90)
                        push_word(dpc_pkg::CMD_MENU, 3'd4);
                    else
                        push_word(dpc_pkg::CMD_MENU, k);
                end
                dpc_pkg::ST_PRODUCT, dpc_pkg::ST_VOLUME: begin
                    if (want_coin || r2 < 15) start_coin(coin_bias);
                    else if (r2 < 30)         push_word(dpc_pkg::CMD_MENU, 3'd4);
                    else                      push_word(dpc_pkg::CMD_MENU, k);
                end
                dpc_pkg::ST_CONFIRM: begin
                    if (r2 < 70)      push_word(dpc_pkg::CMD_MENU, 3'd1);
                    else if (r2 < 90) push_word(dpc_pkg::CMD_MENU, 3'd4);
                    else              push_word(dpc_pkg::CMD_MENU, k);
                end
                default: push_tick();
            endcase
        end
    endtask

    task automatic run_words(input int count, input bit coin_bias);
        repeat (count) plan_next(coin_bias);
    endtask

    // Returns once every queued word has been taken and its result checked.
    task automatic wait_drained();
        while (pending_words.size() != 0 || words_in_flight != 0 ||
               predicted_words.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
        case (idx)
            dpc_pkg::REG_PRICE_ONE:     settings.price_product_one   = val[7:0];
            dpc_pkg::REG_PRICE_TWO:     settings.price_product_two   = val[7:0];
            dpc_pkg::REG_PRICE_THREE:   settings.price_product_three = val[7:0];
            dpc_pkg::REG_DISPENSE_SECS: settings.dispense_seconds    = val[5:0];
            dpc_pkg::REG_COIN_WINDOW:   settings.coin_window_ticks   = val;
            dpc_pkg::REG_KEY_LOCKOUT:   settings.key_lockout_ticks   = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_settings(input logic [15:0] p1, input logic [15:0] p2,
                                 input logic [15:0] p3, input logic [15:0] secs,
                                 input logic [15:0] window, input logic [15:0] lockout);
        write_register(dpc_pkg::REG_PRICE_ONE, p1);
        write_register(dpc_pkg::REG_PRICE_TWO, p2);
        write_register(dpc_pkg::REG_PRICE_THREE, p3);
        write_register(dpc_pkg::REG_DISPENSE_SECS, secs);
        write_register(dpc_pkg::REG_COIN_WINDOW, window);
        write_register(dpc_pkg::REG_KEY_LOCKOUT, lockout);
    endtask

    task automatic show_word(input string tag, input dpc_pkg::out_word_t v);
        $write("  %s mode=%0d bal=%0d prod=%0d vol=%0d cost=%0d", tag,
               v.mode, v.balance, v.chosen_product, v.chosen_volume, v.purchase_cost);
        $display(" pump=%0d en=%0b sec=%0d low=%0b coin=%0d",
                 v.pump_active, v.coin_enable, v.seconds_left, v.short_of_funds,
                 v.coin_outcome);
    endtask

    // Input side: presents queued words, predicts each one as it is taken.
    always @(posedge aclk) begin : word_driver
        dpc_pkg::out_word_t predicted;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_dispenser(live_state, settings, s_data, predicted);
                predicted_words.push_back(predicted);
                words_in_flight--;
            end
            // valid only drops once the held word has been taken
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    s_data  <= pending_words.pop_front();
                    s_valid <= 1'b1;
                    words_in_flight++;
                    if ($urandom_range(0, 99) < send_idle_pct) send_gap = $urandom_range(1, 10);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side: checks each word against the oldest prediction and drives
    // ready, with random stalls and one long hold that backs up the block.
    always @(posedge aclk) begin : result_monitor
        dpc_pkg::out_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (predicted_words.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_MAX) begin
                        $display("result %0d arrived with nothing predicted", results_seen);
                        show_word("actual  ", m_data);
                    end
                end else begin
                    want = predicted_words.pop_front();
                    if (m_data.mode !== want.mode || m_data.balance !== want.balance ||
                        m_data.chosen_product !== want.chosen_product ||
                        m_data.chosen_volume !== want.chosen_volume ||
                        m_data.purchase_cost !== want.purchase_cost ||
                        m_data.pump_active !== want.pump_active ||
                        m_data.coin_enable !== want.coin_enable ||
                        m_data.seconds_left !== want.seconds_left ||
                        m_data.short_of_funds !== want.short_of_funds ||
                        m_data.coin_outcome !== want.coin_outcome) begin
                        error_count++;
                        if (error_count <= REPORT_MAX) begin
                            $display("result %0d mismatch", results_seen);
                            show_word("expected", want);
                            show_word("actual  ", m_data);
                        end
                    end
                end
            end
            if (!long_hold_done && results_seen >= 150) begin
                long_hold_done = 1'b1;
                recv_gap       = 300;
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < recv_idle_pct) begin
                recv_gap = $urandom_range(1, 10) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : run_limit
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int guard;
        settings.price_product_one   = 8'd4;
        settings.price_product_two   = 8'd6;
        settings.price_product_three = 8'd8;
        settings.dispense_seconds    = 6'd10;
        settings.coin_window_ticks   = 16'd1000;
        settings.key_lockout_ticks   = 16'd250;
        live_state = '0;
        plan_state = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values: key still locked out, coin window still open.
        send_idle_pct = 20;
        recv_idle_pct = 20;
        push_word(dpc_pkg::CMD_TICK, 3'd0);
        push_word(dpc_pkg::CMD_TICK, 3'd7);
        push_word(dpc_pkg::CMD_TICK, 3'd0);
        push_word(dpc_pkg::CMD_MENU, 3'd2);
        push_word(dpc_pkg::CMD_COIN, 3'd0);
        push_word(dpc_pkg::CMD_TICK, 3'd0);
        wait_drained();

        // Directed walk: zero window, zero lockout, zero dispense time,
        // extreme and zero prices, short funds, invalid key numbers.
        load_settings(16'd255, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
        push_word(dpc_pkg::CMD_TICK, 3'd0);
        push_word(dpc_pkg::CMD_MENU, 3'd0);
        push_word(dpc_pkg::CMD_MENU, 3'd2);
        push_word(dpc_pkg::CMD_COIN, 3'd0);
        push_word(dpc_pkg::CMD_COIN, 3'd0);
        push_word(dpc_pkg::CMD_TICK, 3'd0);
        push_word(dpc_pkg::CMD_NOZZLE, 3'd0);
        push_word(dpc_pkg::CMD_MENU, 3'd4);
        push_word(dpc_pkg::CMD_TICK, 3'd0);
        push_word(dpc_pkg::CMD_MENU, 3'd1);
        push_word(dpc_pkg::CMD_TICK, 3'd0);
        push_word(dpc_pkg::CMD_MENU, 3'd3);
        push_word(dpc_pkg::CMD_TICK, 3'd0);
        push_word(dpc_pkg::CMD_MENU, 3'd4);
        push_word(dpc_pkg::CMD_TICK, 3'd0);
        push_word(dpc_pkg::CMD_MENU, 3'd2);
        push_word(dpc_pkg::CMD_TICK, 3'd0);
        push_word(dpc_pkg::CMD_MENU, 3'd1);
        push_word(dpc_pkg::CMD_TICK, 3'd0);
        push_word(dpc_pkg::CMD_MENU, 3'd1);
        push_word(dpc_pkg::CMD_TICK, 3'd0);
        push_word(dpc_pkg::CMD_NOZZLE, 3'd2);
        push_word(dpc_pkg::CMD_TICK, 3'd0);
        push_word(dpc_pkg::CMD_MENU, 3'd7);
        push_word(dpc_pkg::CMD_NOZZLE, 3'd7);
        wait_drained();

        // Small prices, short window; the long receiver hold lands here.
        load_settings(16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                      16'($urandom_range(0, 20)), 16'd0, 16'd1, 16'd0);
        run_words(200, 1'b0);
        wait_drained();

        // Coin-heavy stretch at top prices, no idling, then spend.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_settings(16'd255, 16'd255, 16'd255, 16'd0, 16'd0, 16'd1);
        run_words(120, 1'b1);
        run_words(40, 1'b0);
        wait_drained();

        // One-second dispense, random prices.
        send_idle_pct = 20;
        recv_idle_pct = 20;
        load_settings(16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                      16'($urandom_range(0, 255)), 16'd1, 16'd5, 16'd3);
        run_words(150, 1'b0);
        wait_drained();

        // Longest window and lockout: no key gets through.
        send_idle_pct = 30;
        recv_idle_pct = 30;
        load_settings(16'd0, 16'd0, 16'd0, 16'd1, 16'hFFFF, 16'hFFFF);
        run_words(40, 1'b0);
        wait_drained();

        // Last part, no idling: into a sixty-second dispense.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_settings(16'd1, 16'd2, 16'd3, 16'd60, 16'd2, 16'd0);
        guard = 0;
        while (plan_state.menu_state != dpc_pkg::ST_DISPENSE && guard < 120) begin
            plan_next(1'b0);
            guard++;
        end
        run_words(40, 1'b0);
        wait_drained();

        repeat (10) @(posedge aclk);
        if (error_count == 0 && predicted_words.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
